### hw/rtl/rgbpwm_pkg.sv
`default_nettype none

package rgbpwm_pkg;

  localparam int unsigned MaxWriteBytes = 32;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindWrite = 2'd1,
    KindRead  = 2'd2
  } kind_e;

  localparam logic [7:0] CmdBlue     = 8'h81;
  localparam logic [7:0] CmdGreen    = 8'h82;
  localparam logic [7:0] CmdRed      = 8'h83;
  localparam logic [7:0] CmdSettings = 8'h84;
  localparam logic [7:0] CmdAutoInc  = 8'h01;
  localparam logic [7:0] CmdScript   = 8'haa;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       red_on;
    logic       green_on;
    logic       blue_on;
    logic [7:0] reply_status_byte;
    logic [7:0] reply_color_byte;
    logic [7:0] active_script;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/rgbpwm_core.sv
`default_nettype none

module rgbpwm_core #(
  parameter int unsigned MaxWriteBytes = rgbpwm_pkg::MaxWriteBytes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire rgbpwm_pkg::item_t   item_i,
  output rgbpwm_pkg::result_t      result_o
);

  localparam int unsigned PosW = $clog2(MaxWriteBytes + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxWriteBytes);
  localparam logic [PosW-1:0] Pos1   = PosW'(1);
  localparam logic [PosW-1:0] Pos2   = PosW'(2);
  localparam logic [PosW-1:0] Pos3   = PosW'(3);

  // colour levels keep only the high nibble; the low nibble is always zero
  logic [3:0]      red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic            ps_q, ps_d, en_q, en_d;
  logic [7:0]      script_q, script_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [2:0]      pins_q, pins_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      pair_q, pair_d;
  logic [3:0]      held_q [2];
  logic            held_we0, held_we1;

  logic [PosW-1:0] pos;
  logic [7:0]      cmd;
  logic [7:0]      b;

  assign b = item_i.data_byte;

  always_comb begin
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    ps_d     = ps_q;
    en_d     = en_q;
    script_d = script_q;
    cnt_d    = cnt_q;
    pins_d   = pins_q;
    pos_d    = pos_q;
    cmd_d    = cmd_q;
    pair_d   = pair_q;
    held_we0 = 1'b0;
    held_we1 = 1'b0;
    pos      = item_i.first_byte ? '0 : pos_q;
    cmd      = (pos == '0) ? b : cmd_q;

    case (item_i.kind)
      rgbpwm_pkg::KindTick: begin
        cnt_d = cnt_q + 8'd1;
        if (cnt_d == 8'd0) begin
          pins_d[0] = pins_q[0] | (red_q   != 4'd0);
          pins_d[1] = pins_q[1] | (green_q != 4'd0);
          pins_d[2] = pins_q[2] | (blue_q  != 4'd0);
        end
        // a level of 255 cannot occur, so the compare alone turns off
        if (cnt_d == {red_q, 4'h0})   pins_d[0] = 1'b0;
        if (cnt_d == {green_q, 4'h0}) pins_d[1] = 1'b0;
        if (cnt_d == {blue_q, 4'h0})  pins_d[2] = 1'b0;
      end
      rgbpwm_pkg::KindWrite: begin
        if (pos < PosMax) begin
          if (pos == '0) begin
            cmd_d = b;
            if (b == rgbpwm_pkg::CmdScript) begin
              red_d   = 4'd0;
              green_d = 4'd0;
              blue_d  = 4'd0;
            end
          end
          case (cmd)
            rgbpwm_pkg::CmdSettings: begin
              if (pos == Pos1) begin
                ps_d = b[0];
                en_d = b[1];
              end
            end
            rgbpwm_pkg::CmdBlue, rgbpwm_pkg::CmdGreen, rgbpwm_pkg::CmdRed: begin
              if (!pos[0]) begin
                pair_d = b;
              end else begin
                case (pair_q)
                  rgbpwm_pkg::CmdBlue:  blue_d  = b[3:0];
                  rgbpwm_pkg::CmdGreen: green_d = b[3:0];
                  rgbpwm_pkg::CmdRed:   red_d   = b[3:0];
                  default: ;
                endcase
              end
            end
            rgbpwm_pkg::CmdAutoInc: begin
              if (pos == Pos1) begin
                held_we0 = 1'b1;
              end else if (pos == Pos2) begin
                held_we1 = 1'b1;
              end else if (pos == Pos3 && item_i.last_byte) begin
                blue_d  = held_q[0];
                green_d = held_q[1];
                red_d   = b[3:0];
              end
            end
            rgbpwm_pkg::CmdScript: begin
              if (pos == Pos1) script_d = b;
            end
            default: ;
          endcase
          pos_d = pos + Pos1;
        end
        if (item_i.last_byte) pos_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      ps_q     <= 1'b0;
      en_q     <= 1'b0;
      script_q <= '0;
      cnt_q    <= '0;
      pins_q   <= '0;
      pos_q    <= '0;
      cmd_q    <= '0;
      pair_q   <= '0;
    end else if (step_i) begin
      red_q    <= red_d;
      green_q  <= green_d;
      blue_q   <= blue_d;
      ps_q     <= ps_d;
      en_q     <= en_d;
      script_q <= script_d;
      cnt_q    <= cnt_d;
      pins_q   <= pins_d;
      pos_q    <= pos_d;
      cmd_q    <= cmd_d;
      pair_q   <= pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && held_we0) held_q[0] <= b[3:0];
    if (step_i && held_we1) held_q[1] <= b[3:0];
  end

  // result reflects the state after this item
  assign result_o.red_on            = pins_d[0];
  assign result_o.green_on          = pins_d[1];
  assign result_o.blue_on           = pins_d[2];
  assign result_o.reply_status_byte = {2'b00, en_d, ps_d, blue_d};
  assign result_o.reply_color_byte  = {green_d, red_d};
  assign result_o.active_script     = script_d;

endmodule

`default_nettype wire

### hw/rtl/rgb_led_register_pwm_driver_top.sv
`default_nettype none
// A request passes the input reg, the state update, then the result reg.
// Throughput: one request per cycle while results are taken.
// A result that is not taken holds the result reg; the input reg then holds once full.
// Reset: asynchronous, active low; colours, flags, counter and pins clear to zero.

module rgb_led_register_pwm_driver_top #(
  parameter int unsigned MaxWriteBytes = rgbpwm_pkg::MaxWriteBytes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire rgbpwm_pkg::item_t   in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      rgbpwm_pkg::result_t out_result_o
);

  logic                s1_valid_q;
  rgbpwm_pkg::item_t   s1_item_q;
  logic                out_valid_q;
  rgbpwm_pkg::result_t out_q;
  rgbpwm_pkg::result_t res;
  logic                adv;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;

  rgbpwm_core #(
    .MaxWriteBytes(MaxWriteBytes)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_valid_q && adv),
    .item_i  (s1_item_q),
    .result_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) s1_item_q <= in_item_i;
    if (adv && s1_valid_q) out_q <= res;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

`default_nettype wire

### sim/rgbpwm_checker.sv
module rgbpwm_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  rgbpwm_pkg::item_t   in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  rgbpwm_pkg::result_t out_result_i,
  output int                  err_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] LevelFull = 8'hff;

  // shadow of the controller state
  logic [7:0] red_lvl   = '0;
  logic [7:0] grn_lvl   = '0;
  logic [7:0] blu_lvl   = '0;
  logic       powersave = 1'b0;
  logic       enable    = 1'b0;
  logic [7:0] script_no = '0;
  logic [7:0] pwm_cnt   = '0;
  logic [2:0] pins      = '0;  // {blue, green, red}
  logic [5:0] byte_pos  = '0;
  logic [7:0] cmd_code  = '0;
  logic [7:0] pair_addr = '0;
  logic [7:0] held [2];

  rgbpwm_pkg::result_t led_results[$];
  int      mismatches = 0;
  int      waiting    = 0;

  assign err_count_o = mismatches;
  assign pending_o   = waiting;

  task automatic pwm_advance();
    pwm_cnt = pwm_cnt + 8'd1;
    if (pwm_cnt == 8'd0) begin
      if (red_lvl != 8'd0) pins[0] = 1'b1;
      if (grn_lvl != 8'd0) pins[1] = 1'b1;
      if (blu_lvl != 8'd0) pins[2] = 1'b1;
    end
    if (red_lvl != LevelFull && pwm_cnt == red_lvl) pins[0] = 1'b0;
    if (grn_lvl != LevelFull && pwm_cnt == grn_lvl) pins[1] = 1'b0;
    if (blu_lvl != LevelFull && pwm_cnt == blu_lvl) pins[2] = 1'b0;
  endtask

  task automatic bus_write(input logic [7:0] data, input logic first_b, input logic last_b);
    logic [5:0] pos;
    if (first_b) byte_pos = '0;
    pos = byte_pos;
    if (pos < rgbpwm_pkg::MaxWriteBytes) begin
      if (pos == 6'd0) begin
        cmd_code = data;
        // script clears the colours as soon as the command byte lands
        if (data == rgbpwm_pkg::CmdScript) begin
          red_lvl = '0;
          grn_lvl = '0;
          blu_lvl = '0;
        end
      end
      case (cmd_code)
        rgbpwm_pkg::CmdSettings: begin
          if (pos == 6'd1) begin
            powersave = data[0];
            enable    = data[1];
          end
        end
        rgbpwm_pkg::CmdBlue, rgbpwm_pkg::CmdGreen, rgbpwm_pkg::CmdRed: begin
          if (!pos[0]) begin
            pair_addr = data;
          end else begin
            case (pair_addr)
              rgbpwm_pkg::CmdBlue:  blu_lvl = {data[3:0], 4'h0};
              rgbpwm_pkg::CmdGreen: grn_lvl = {data[3:0], 4'h0};
              rgbpwm_pkg::CmdRed:   red_lvl = {data[3:0], 4'h0};
              default: ;
            endcase
          end
        end
        rgbpwm_pkg::CmdAutoInc: begin
          if (pos == 6'd1) begin
            held[0] = data;
          end else if (pos == 6'd2) begin
            held[1] = data;
          end else if (pos == 6'd3 && last_b) begin
            blu_lvl = {held[0][3:0], 4'h0};
            grn_lvl = {held[1][3:0], 4'h0};
            red_lvl = {data[3:0], 4'h0};
          end
        end
        rgbpwm_pkg::CmdScript: begin
          if (pos == 6'd1) script_no = data;
        end
        default: ;
      endcase
      byte_pos = pos + 6'd1;
    end
    if (last_b) byte_pos = '0;
  endtask

  function automatic rgbpwm_pkg::result_t led_snapshot();
    rgbpwm_pkg::result_t r;
    r.red_on            = pins[0];
    r.green_on          = pins[1];
    r.blue_on           = pins[2];
    r.reply_status_byte = {2'b00, enable, powersave, blu_lvl[7:4]};
    r.reply_color_byte  = {grn_lvl[7:4], red_lvl[7:4]};
    r.active_script     = script_no;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch, expected %02h, got %02h", $realtime, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    rgbpwm_pkg::result_t want;
    if (rst_ni) begin
      // retire first so a result can never match a request taken on the same edge
      if (out_valid_i && out_ready_i) begin
        if (led_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result %h with no request outstanding", $realtime, out_result_i);
          mismatches++;
        end else begin
          want = led_results.pop_front();
          compare_field("red_on", 8'(want.red_on), 8'(out_result_i.red_on));
          compare_field("green_on", 8'(want.green_on), 8'(out_result_i.green_on));
          compare_field("blue_on", 8'(want.blue_on), 8'(out_result_i.blue_on));
          compare_field("reply_status_byte", want.reply_status_byte,
                        out_result_i.reply_status_byte);
          compare_field("reply_color_byte", want.reply_color_byte,
                        out_result_i.reply_color_byte);
          compare_field("active_script", want.active_script, out_result_i.active_script);
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_item_i.kind)
          rgbpwm_pkg::KindTick:  pwm_advance();
          rgbpwm_pkg::KindWrite: bus_write(in_item_i.data_byte, in_item_i.first_byte,
                                           in_item_i.last_byte);
          default: ;
        endcase
        led_results.push_back(led_snapshot());
      end
      waiting = led_results.size();
    end
  end

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KindSpare = 2'd3;  // unused kind, must leave state alone
  localparam int RequestTarget = 440;
  localparam int HoldAt        = 120;
  localparam int HoldCycles    = 60;
  localparam int PauseAt       = 260;

  logic    clk_i    = 1'b0;
  logic    rst_n    = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  rgbpwm_pkg::item_t   in_item  = '0;
  logic    out_valid;
  logic    out_ready;
  logic    rx_ready = 1'b0;
  logic    rx_hold  = 1'b0;
  rgbpwm_pkg::result_t out_result;
  int      err_count;
  int      pending;
  int      sent_items = 0;

  rgbpwm_pkg::item_t requests[$];
  logic [7:0] frame[$];

  assign out_ready = rx_ready && !rx_hold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_led_register_pwm_driver_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_item_i    (in_item),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_result_o (out_result)
  );

  rgbpwm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_result_i (out_result),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic add_item(input logic [1:0] kind, input logic [7:0] data,
                          input logic first_b, input logic last_b);
    rgbpwm_pkg::item_t it;
    it.kind       = kind;
    it.data_byte  = data;
    it.first_byte = first_b;
    it.last_byte  = last_b;
    requests.push_back(it);
  endtask

  // one bus write from the bytes gathered in frame, last flag on the final byte
  task automatic flush_frame(input bit with_first);
    foreach (frame[k])
      add_item(rgbpwm_pkg::KindWrite, frame[k], with_first && k == 0,
               k == frame.size() - 1);
    frame.delete();
  endtask

  function automatic logic [7:0] pair_cmd();
    case ($urandom_range(0, 2))
      0:       return rgbpwm_pkg::CmdBlue;
      1:       return rgbpwm_pkg::CmdGreen;
      default: return rgbpwm_pkg::CmdRed;
    endcase
  endfunction

  task automatic build_requests();
    int pick;
    int len;
    bit with_first;
    // directed opening
    frame = '{rgbpwm_pkg::CmdSettings, 8'h03};
    flush_frame(1);
    // red address has no data
    frame = '{rgbpwm_pkg::CmdBlue, 8'hff, rgbpwm_pkg::CmdGreen, 8'h0f, rgbpwm_pkg::CmdRed};
    flush_frame(1);
    frame = '{rgbpwm_pkg::CmdAutoInc, 8'h05, 8'h0a, 8'hff};
    flush_frame(1);
    add_item(rgbpwm_pkg::KindRead, 8'h00, 1'b0, 1'b0);
    add_item(KindSpare, 8'hff, 1'b1, 1'b1);
    add_item(rgbpwm_pkg::KindTick, 8'h00, 1'b0, 1'b0);
    add_item(rgbpwm_pkg::KindTick, 8'hff, 1'b1, 1'b1);
    frame = '{rgbpwm_pkg::CmdAutoInc, 8'h07, 8'h08};  // too short to apply
    flush_frame(1);
    frame = '{8'h00, 8'h55};              // unknown command, no first flag
    flush_frame(0);
    frame = '{rgbpwm_pkg::CmdSettings};   // settings with no data byte
    flush_frame(1);
    frame = '{rgbpwm_pkg::CmdScript, 8'hff};
    flush_frame(1);
    add_item(rgbpwm_pkg::KindRead, 8'hff, 1'b1, 1'b1);

    while (requests.size() < RequestTarget) begin
      pick       = $urandom_range(0, 99);
      with_first = $urandom_range(0, 3) != 0;
      if (pick < 30) begin
        repeat ($urandom_range(1, 48))
          add_item(rgbpwm_pkg::KindTick, rand_byte(), rand_bit(), rand_bit());
      end else if (pick < 42) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          frame.push_back((k > 0 && $urandom_range(0, 5) == 0) ? rand_byte() : pair_cmd());
          frame.push_back(rand_byte());
        end
        if ($urandom_range(0, 4) == 0) void'(frame.pop_back());
        flush_frame(with_first);
      end else if (pick < 52) begin
        len = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(1, 6);
        frame.push_back(rgbpwm_pkg::CmdAutoInc);
        repeat (len - 1) frame.push_back(rand_byte());
        flush_frame(with_first);
      end else if (pick < 60) begin
        len = ($urandom_range(0, 2) != 0) ? 2 : $urandom_range(1, 3);
        frame.push_back(rgbpwm_pkg::CmdSettings);
        repeat (len - 1) frame.push_back(rand_byte());
        flush_frame(with_first);
      end else if (pick < 66) begin
        len = ($urandom_range(0, 2) != 0) ? 2 : $urandom_range(1, 3);
        frame.push_back(rgbpwm_pkg::CmdScript);
        repeat (len - 1) frame.push_back(rand_byte());
        flush_frame(with_first);
      end else if (pick < 74) begin
        repeat ($urandom_range(1, 3))
          add_item(rgbpwm_pkg::KindRead, rand_byte(), rand_bit(), rand_bit());
      end else if (pick < 78) begin
        // can run past the write length limit
        frame.push_back($urandom_range(0, 3) != 0 ? pair_cmd() : rand_byte());
        repeat ($urandom_range(29, 39)) frame.push_back(rand_byte());
        flush_frame(with_first);
      end else if (pick < 82) begin
        add_item(KindSpare, rand_byte(), rand_bit(), rand_bit());
      end else begin
        repeat ($urandom_range(1, 4))
          add_item(rgbpwm_pkg::KindWrite, rand_byte(), rand_bit(), rand_bit());
      end
    end
  endtask

  initial begin : sender
    int gap;
    build_requests();
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < requests.size(); i++) begin
      gap = (i % 100 < 20) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid <= 1'b1;
      in_item  <= requests[i];
      @(posedge clk_i);
      while (!in_ready) @(posedge clk_i);
      sent_items = i + 1;
      if (i == PauseAt) begin
        // let the pipeline drain completely before carrying on
        in_valid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : receiver
    int gap;
    int n;
    n = 0;
    wait (rst_n);
    forever begin
      gap = (n % 80 < 16) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        rx_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rx_ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid && out_ready)) @(posedge clk_i);
      n++;
    end
  end

  // long back-pressure so the block fills and stalls its request side
  initial begin : backpressure
    wait (sent_items >= HoldAt);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
